// File: design/rpc_pkg.sv
`default_nettype none

package rpc_pkg;

    // Store geometry.
    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLS    = 256;
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int ADDR_W      = ROW_W + COL_W;
    localparam int STORE_DEPTH = 2 ** ADDR_W;

    // Field and register widths.
    localparam int SAMPLE_W = 16;
    localparam int ROWC_W   = 7;
    localparam int COLC_W   = 9;
    localparam int CFG_W    = 9;
    localparam int Q_W      = 15;

    // Accumulator and variance widths.
    localparam int SX_W  = SAMPLE_W + COL_W;
    localparam int ACC_W = 2 * SAMPLE_W + COL_W;
    localparam int V_W   = ACC_W + COL_W + 2;

    // Serial multiplier operand widths.
    localparam int MB_W = V_W;
    localparam int MA_W = 2 * V_W + 32;

    // Opcodes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Register indexes.
    localparam logic CFG_ROW_COUNT = 1'b0;
    localparam logic CFG_COL_COUNT = 1'b1;

    // Reset values.
    localparam logic [ROWC_W-1:0] ROWC_RESET = 7'd64;
    localparam logic [COLC_W-1:0] COLC_RESET = 9'd256;

    // Request to the shared multiplier.
    typedef struct packed {
        logic            start;
        logic [MA_W-1:0] a;
        logic [MB_W-1:0] b;
    } t_mul_req;

    // Response of the shared multiplier.
    typedef struct packed {
        logic            busy;
        logic            done;
        logic [MA_W-1:0] product;
    } t_mul_rsp;

endpackage

`default_nettype wire

// File: design/rpc_in_if.sv
`default_nettype none

interface rpc_in_if;
    logic                                valid;
    logic                                ready;
    logic                                opcode;
    logic [rpc_pkg::ROW_W-1:0]           row;
    logic [rpc_pkg::COL_W-1:0]           column;
    logic signed [rpc_pkg::SAMPLE_W-1:0] sample;
    logic [rpc_pkg::ROW_W-1:0]           other_row;

    modport source (output valid, opcode, row, column, sample, other_row, input ready);
    modport sink   (input valid, opcode, row, column, sample, other_row, output ready);
endinterface

`default_nettype wire

// File: design/rpc_out_if.sv
`default_nettype none

interface rpc_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [rpc_pkg::SAMPLE_W-1:0] correlation;
    logic                                degenerate;

    modport source (output valid, correlation, degenerate, input ready);
    modport sink   (input valid, correlation, degenerate, output ready);
endinterface

`default_nettype wire

// File: design/rpc_store.sv
`default_nettype none

module rpc_store (
    input  wire logic                         i_clk,
    input  wire logic                         i_we,
    input  wire logic [rpc_pkg::ADDR_W-1:0]   i_waddr,
    input  wire logic [rpc_pkg::SAMPLE_W-1:0] i_wdata,
    input  wire logic [rpc_pkg::ADDR_W-1:0]   i_raddr,
    output logic [rpc_pkg::SAMPLE_W-1:0]      o_rdata
);

    logic [rpc_pkg::SAMPLE_W-1:0] r_mem [0:rpc_pkg::STORE_DEPTH-1];
    logic [rpc_pkg::SAMPLE_W-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: design/rpc_mul.sv
`default_nettype none

module rpc_mul (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rpc_pkg::t_mul_req i_req,
    output rpc_pkg::t_mul_rsp      o_rsp
);

    logic                     r_busy;
    logic                     r_done;
    logic [rpc_pkg::MA_W-1:0] r_a;
    logic [rpc_pkg::MB_W-1:0] r_b;
    logic [rpc_pkg::MA_W-1:0] r_acc;

    // Shift-add multiplier: one multiplier bit per cycle, ends once the
    // remaining multiplier bits are all zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_acc  <= '0;
            end else if (r_busy) begin
                if (r_b == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    if (r_b[0]) begin
                        r_acc <= r_acc + r_a;
                    end
                    r_a <= r_a << 1;
                    r_b <= r_b >> 1;
                end
            end
        end
    end

    assign o_rsp.busy    = r_busy;
    assign o_rsp.done    = r_done;
    assign o_rsp.product = r_acc;

endmodule

`default_nettype wire

// File: design/row_pair_correlation_top.sv
`default_nettype none
// Channel | Direction | Payload                                    | Handshake
// i_in    | in        | opcode, row, column, sample, other_row     | valid/ready
// o_out   | out       | correlation, degenerate                    | valid/ready
// cfg     | in        | i_cfg_idx, i_cfg_data                      | i_cfg_we
//
// A query makes two store reads per column on the single read port, then uses the
// serial shift-add multiplier, which forms both wide products and 15 bisection steps.
// One item is in work at a time; i_in.ready is low while a query runs.
// A finished result waits in the output register; the block returns to idle
// once the result is loaded. Reset is synchronous and active low.

module row_pair_correlation_top (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    rpc_in_if.sink                          i_in,
    rpc_out_if.source                       o_out,
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_idx,
    input  wire logic [rpc_pkg::CFG_W-1:0]  i_cfg_data
);

    localparam logic [1:0] K_XX = 2'd0;
    localparam logic [1:0] K_YY = 2'd1;
    localparam logic [1:0] K_XY = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_RDX, S_RDY, S_ACC, S_VP, S_VS, S_CHK,
        S_M1W, S_M2W, S_MID, S_ODDW, S_LHSW, S_FIN
    } t_state;

    t_state                                 r_state;
    logic [rpc_pkg::ROWC_W-1:0]             r_row_count;
    logic [rpc_pkg::COLC_W-1:0]             r_col_count;
    logic [rpc_pkg::ROW_W-1:0]              r_ra;
    logic [rpc_pkg::ROW_W-1:0]              r_rb;
    logic [rpc_pkg::COL_W-1:0]              r_c;
    logic [rpc_pkg::COLC_W-1:0]             r_n;
    logic signed [rpc_pkg::SAMPLE_W-1:0]    r_x;
    logic signed [rpc_pkg::SX_W-1:0]        r_sx;
    logic signed [rpc_pkg::SX_W-1:0]        r_sy;
    logic signed [rpc_pkg::ACC_W-1:0]       r_sxx;
    logic signed [rpc_pkg::ACC_W-1:0]       r_syy;
    logic signed [rpc_pkg::ACC_W-1:0]       r_sxy;
    logic [1:0]                             r_k;
    logic signed [rpc_pkg::V_W-1:0]         r_p1;
    logic signed [rpc_pkg::V_W-1:0]         r_p2;
    logic signed [rpc_pkg::V_W-1:0]         r_vxx;
    logic signed [rpc_pkg::V_W-1:0]         r_vyy;
    logic signed [rpc_pkg::V_W-1:0]         r_vxy;
    logic [rpc_pkg::MA_W-1:0]               r_lhs;
    logic [rpc_pkg::MA_W-1:0]               r_rhs;
    logic [rpc_pkg::Q_W-1:0]                r_lo;
    logic [rpc_pkg::Q_W-1:0]                r_hi;
    logic [rpc_pkg::Q_W-1:0]                r_mid;
    rpc_pkg::t_mul_req                      r_req;
    logic signed [rpc_pkg::SAMPLE_W-1:0]    r_res_corr;
    logic                                   r_res_deg;
    logic                                   r_out_valid;
    logic signed [rpc_pkg::SAMPLE_W-1:0]    r_out_corr;
    logic                                   r_out_deg;

    rpc_pkg::t_mul_rsp                      w_rsp;
    logic [rpc_pkg::ROWC_W-1:0]             w_nr;
    logic [rpc_pkg::COLC_W-1:0]             w_n;
    logic                                   w_accept;
    logic                                   w_we;
    logic [rpc_pkg::ADDR_W-1:0]             w_raddr;
    logic [rpc_pkg::SAMPLE_W-1:0]           w_rdata;
    logic signed [rpc_pkg::SAMPLE_W-1:0]    w_y;
    logic signed [31:0]                     w_xx;
    logic signed [31:0]                     w_yy;
    logic signed [31:0]                     w_xy;
    logic signed [rpc_pkg::ACC_W-1:0]       w_s;
    logic signed [rpc_pkg::SX_W-1:0]        w_a;
    logic signed [rpc_pkg::SX_W-1:0]        w_b;
    logic signed [rpc_pkg::V_W-1:0]         w_p1;
    logic signed [rpc_pkg::V_W-1:0]         w_p2;
    logic signed [rpc_pkg::V_W-1:0]         w_mag;
    logic [rpc_pkg::Q_W:0]                  w_mid_sum;
    logic [rpc_pkg::Q_W-1:0]                w_mid;
    logic [rpc_pkg::Q_W:0]                  w_odd;
    logic signed [rpc_pkg::SAMPLE_W-1:0]    w_corr;

    // Rows and columns in use, saturated to the store size.
    assign w_nr = (r_row_count > rpc_pkg::ROWC_W'(rpc_pkg::MAX_ROWS))
                ? rpc_pkg::ROWC_W'(rpc_pkg::MAX_ROWS) : r_row_count;
    assign w_n  = (r_col_count > rpc_pkg::COLC_W'(rpc_pkg::MAX_COLS))
                ? rpc_pkg::COLC_W'(rpc_pkg::MAX_COLS) : r_col_count;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_we       = w_accept && (i_in.opcode == rpc_pkg::OP_WRITE)
                     && ({1'b0, i_in.row} < w_nr) && ({1'b0, i_in.column} < w_n);

    // Read address: first row, second row, then first row of the next column.
    always_comb begin
        case (r_state)
            S_RDY:   w_raddr = {r_rb, r_c};
            S_ACC:   w_raddr = {r_ra, r_c + rpc_pkg::COL_W'(1)};
            default: w_raddr = {r_ra, r_c};
        endcase
    end

    rpc_store u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr ({i_in.row, i_in.column}),
        .i_wdata (i_in.sample),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    rpc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_rsp   (w_rsp)
    );

    // Per-column products.
    assign w_y  = $signed(w_rdata);
    assign w_xx = 32'(r_x) * 32'(r_x);
    assign w_yy = 32'(w_y) * 32'(w_y);
    assign w_xy = 32'(r_x) * 32'(w_y);

    // Operands of n*S - A*B for the selected variance term.
    always_comb begin
        case (r_k)
            K_XX: begin
                w_s = r_sxx;
                w_a = r_sx;
                w_b = r_sx;
            end
            K_YY: begin
                w_s = r_syy;
                w_a = r_sy;
                w_b = r_sy;
            end
            default: begin
                w_s = r_sxy;
                w_a = r_sx;
                w_b = r_sy;
            end
        endcase
    end

    assign w_p1 = rpc_pkg::V_W'($signed({1'b0, r_n})) * rpc_pkg::V_W'(w_s);
    assign w_p2 = rpc_pkg::V_W'(w_a) * rpc_pkg::V_W'(w_b);
    assign w_mag = r_vxy[rpc_pkg::V_W-1] ? -r_vxy : r_vxy;

    // Bisection midpoint and the odd factor 2*mid - 1.
    assign w_mid_sum = {1'b0, r_lo} + {1'b0, r_hi} + (rpc_pkg::Q_W+1)'(1);
    assign w_mid     = w_mid_sum[rpc_pkg::Q_W:1];
    assign w_odd     = {w_mid, 1'b0} - (rpc_pkg::Q_W+1)'(1);
    assign w_corr    = r_vxy[rpc_pkg::V_W-1] ? -$signed({1'b0, r_lo}) : $signed({1'b0, r_lo});

    // Sequencer, configuration and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_count <= rpc_pkg::ROWC_RESET;
            r_col_count <= rpc_pkg::COLC_RESET;
            r_req.start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_req.start <= 1'b0;
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rpc_pkg::CFG_ROW_COUNT: r_row_count <= i_cfg_data[rpc_pkg::ROWC_W-1:0];
                    rpc_pkg::CFG_COL_COUNT: r_col_count <= i_cfg_data[rpc_pkg::COLC_W-1:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept && (i_in.opcode == rpc_pkg::OP_QUERY)
                        && ({1'b0, i_in.row} < w_nr) && ({1'b0, i_in.other_row} < w_nr)) begin
                        r_ra  <= i_in.row;
                        r_rb  <= i_in.other_row;
                        r_c   <= '0;
                        r_n   <= w_n;
                        r_sx  <= '0;
                        r_sy  <= '0;
                        r_sxx <= '0;
                        r_syy <= '0;
                        r_sxy <= '0;
                        r_k   <= K_XX;
                        if (w_n == '0) begin
                            r_res_corr <= '0;
                            r_res_deg  <= 1'b1;
                            r_state    <= S_FIN;
                        end else begin
                            r_state <= S_RDX;
                        end
                    end
                end
                S_RDX: begin
                    r_state <= S_RDY;
                end
                S_RDY: begin
                    r_x     <= $signed(w_rdata);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_sx  <= r_sx + rpc_pkg::SX_W'(r_x);
                    r_sy  <= r_sy + rpc_pkg::SX_W'(w_y);
                    r_sxx <= r_sxx + rpc_pkg::ACC_W'(w_xx);
                    r_syy <= r_syy + rpc_pkg::ACC_W'(w_yy);
                    r_sxy <= r_sxy + rpc_pkg::ACC_W'(w_xy);
                    if ({1'b0, r_c} == r_n - rpc_pkg::COLC_W'(1)) begin
                        r_state <= S_VP;
                    end else begin
                        r_c     <= r_c + rpc_pkg::COL_W'(1);
                        r_state <= S_RDY;
                    end
                end
                S_VP: begin
                    r_p1    <= w_p1;
                    r_p2    <= w_p2;
                    r_state <= S_VS;
                end
                S_VS: begin
                    case (r_k)
                        K_XX:    r_vxx <= r_p1 - r_p2;
                        K_YY:    r_vyy <= r_p1 - r_p2;
                        default: r_vxy <= r_p1 - r_p2;
                    endcase
                    if (r_k == K_XY) begin
                        r_state <= S_CHK;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_VP;
                    end
                end
                S_CHK: begin
                    // Zero variance in either row gives a degenerate result.
                    if (r_vxx[rpc_pkg::V_W-1] || (r_vxx == '0)
                        || r_vyy[rpc_pkg::V_W-1] || (r_vyy == '0)) begin
                        r_res_corr <= '0;
                        r_res_deg  <= 1'b1;
                        r_state    <= S_FIN;
                    end else begin
                        r_req.start <= 1'b1;
                        r_req.a     <= rpc_pkg::MA_W'($unsigned(r_vxx));
                        r_req.b     <= $unsigned(r_vyy);
                        r_state     <= S_M1W;
                    end
                end
                S_M1W: begin
                    if (w_rsp.done) begin
                        r_lhs       <= w_rsp.product;
                        r_req.start <= 1'b1;
                        r_req.a     <= rpc_pkg::MA_W'($unsigned(w_mag));
                        r_req.b     <= $unsigned(w_mag);
                        r_state     <= S_M2W;
                    end
                end
                S_M2W: begin
                    if (w_rsp.done) begin
                        r_rhs   <= w_rsp.product << 32;
                        r_lo    <= '0;
                        r_hi    <= '1;
                        r_state <= S_MID;
                    end
                end
                S_MID: begin
                    if (r_lo < r_hi) begin
                        r_mid       <= w_mid;
                        r_req.start <= 1'b1;
                        r_req.a     <= rpc_pkg::MA_W'(w_odd);
                        r_req.b     <= rpc_pkg::MB_W'(w_odd);
                        r_state     <= S_ODDW;
                    end else begin
                        r_res_corr <= w_corr;
                        r_res_deg  <= 1'b0;
                        r_state    <= S_FIN;
                    end
                end
                S_ODDW: begin
                    if (w_rsp.done) begin
                        r_req.start <= 1'b1;
                        r_req.a     <= r_lhs;
                        r_req.b     <= w_rsp.product[rpc_pkg::MB_W-1:0];
                        r_state     <= S_LHSW;
                    end
                end
                S_LHSW: begin
                    if (w_rsp.done) begin
                        if (w_rsp.product <= r_rhs) begin
                            r_lo <= r_mid;
                        end else begin
                            r_hi <= r_mid - rpc_pkg::Q_W'(1);
                        end
                        r_state <= S_MID;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_corr  <= r_res_corr;
                        r_out_deg   <= r_res_deg;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.correlation = r_out_corr;
    assign o_out.degenerate  = r_out_deg;

    // A degenerate result always carries a zero correlation.
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.degenerate |-> o_out.correlation == '0)
        else $error("degenerate result with nonzero correlation");

    // The correlation never reaches the most negative code.
    a_no_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.correlation[15] && (o_out.correlation[14:0] == '0)))
        else $error("correlation out of range");

    // The multiplier is never started while it is still working.
    a_mul_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_req.start |-> !w_rsp.busy)
        else $error("multiplier started while busy");

    // The bisection bounds stay ordered.
    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MID) |-> (r_lo <= r_hi))
        else $error("bisection bounds crossed");

endmodule

`default_nettype wire

// File: dv/rpc_corr_checker.sv
`timescale 1ns / 100ps

module rpc_corr_checker (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    rpc_in_if                              i_in,
    rpc_out_if                             i_out,
    input  wire logic                      i_cfg_we,
    input  wire logic                      i_cfg_idx,
    input  wire logic [rpc_pkg::CFG_W-1:0] i_cfg_data,
    output int                             o_errors,
    output int                             o_pending
);
    import rpc_pkg::*;

    typedef struct {
        logic signed [SAMPLE_W-1:0] correlation;
        logic                       degenerate;
    } t_corr_result;

    logic signed [SAMPLE_W-1:0] sample_mem [MAX_ROWS][MAX_COLS];
    logic [ROWC_W-1:0]          row_count;
    logic [COLC_W-1:0]          col_count;
    t_corr_result               corr_expected [$];

    assign o_pending = corr_expected.size();

    function automatic int rows_used();
        return (row_count > MAX_ROWS) ? MAX_ROWS : int'(row_count);
    endfunction

    function automatic int cols_used();
        return (col_count > MAX_COLS) ? MAX_COLS : int'(col_count);
    endfunction

    // Exact Pearson correlation in Q1.15 by bisection on the squared ratio.
    function automatic t_corr_result pearson_q15(int ra, int rb);
        t_corr_result res;
        longint       sx, sy, sxx, syy, sxy, x, y, vxx, vyy, vxy, n;
        logic [127:0] lhs, rhs, prod;
        logic [63:0]  mag, odd;
        int           lo, hi, mid;
        n = cols_used();
        sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
        for (int c = 0; c < n; c++) begin
            x = sample_mem[ra][c];
            y = sample_mem[rb][c];
            sx += x;
            sy += y;
            sxx += x * x;
            syy += y * y;
            sxy += x * y;
        end
        vxx = n * sxx - sx * sx;
        vyy = n * syy - sy * sy;
        vxy = n * sxy - sx * sy;
        res.correlation = '0;
        res.degenerate = 1'b1;
        if (vxx <= 0 || vyy <= 0) begin
            return res;
        end
        mag = (vxy < 0) ? 64'(-vxy) : 64'(vxy);
        lhs = 128'(vxx) * 128'(vyy);
        rhs = (128'(mag) * 128'(mag)) << 32;
        lo = 0;
        hi = 32767;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            odd = 64'(2 * mid - 1);
            prod = lhs * 128'(odd * odd);
            if (prod <= rhs) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        res.correlation = (vxy < 0) ? -16'(lo) : 16'(lo);
        res.degenerate = 1'b0;
        return res;
    endfunction

    // Track register writes, stored samples and queries; compare each result beat.
    always @(posedge i_clk) begin
        t_corr_result got, exp_res;
        if (!i_rst_n) begin
            row_count <= ROWC_RESET;
            col_count <= COLC_RESET;
            corr_expected.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_ROW_COUNT) begin
                    row_count <= i_cfg_data[ROWC_W-1:0];
                end else begin
                    col_count <= i_cfg_data[COLC_W-1:0];
                end
            end
            if (i_in.valid && i_in.ready) begin
                if (i_in.opcode == OP_WRITE) begin
                    if (i_in.row < rows_used() && i_in.column < cols_used()) begin
                        sample_mem[i_in.row][i_in.column] = i_in.sample;
                    end
                end else if (i_in.row < rows_used() && i_in.other_row < rows_used()) begin
                    corr_expected.push_back(pearson_q15(i_in.row, i_in.other_row));
                end
            end
            if (i_out.valid && i_out.ready) begin
                got.correlation = i_out.correlation;
                got.degenerate = i_out.degenerate;
                if (corr_expected.size() == 0) begin
                    $display("%0t: unexpected result beat: correlation %0d degenerate %0b",
                             $time, got.correlation, got.degenerate);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_res = corr_expected.pop_front();
                    if (got.correlation !== exp_res.correlation ||
                        got.degenerate !== exp_res.degenerate) begin
                        $display("%0t: mismatch: expected %0d/%0b, actual %0d/%0b", $time,
                                 exp_res.correlation, exp_res.degenerate,
                                 got.correlation, got.degenerate);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

// File: dv/tb_row_pair_correlation_top.sv
`timescale 1ns / 100ps

module tb_row_pair_correlation_top;
    import rpc_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 2 * MAX_COLS + 1200;

    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_we;
    logic               cfg_idx;
    logic [CFG_W-1:0]   cfg_data;
    int                 errors;
    int                 pending;
    int                 cycles;
    bit                 no_gaps;

    // Stimulus-side copy of the samples and of which entries were written.
    logic signed [SAMPLE_W-1:0] shadow [MAX_ROWS][MAX_COLS];
    bit                         written [MAX_ROWS][MAX_COLS];
    int                         nr, nc;

    rpc_in_if  in_ch ();
    rpc_out_if out_ch ();

    row_pair_correlation_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    rpc_corr_checker checker_i (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .i_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Run limit.
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: random stall before each beat, none while no_gaps is set.
    initial begin
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!no_gaps) begin
                out_ch.ready = 1'b0;
                repeat ($urandom_range(0, 14)) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
            while (!out_ch.valid) @(negedge i_clk);
            @(posedge i_clk);
        end
    end

    task automatic cfg_write(logic idx, int value);
        cfg_idx = idx;
        cfg_data = CFG_W'(value);
        cfg_we = 1'b1;
        @(negedge i_clk);
        cfg_we = 1'b0;
        if (idx == CFG_ROW_COUNT) begin
            nr = ((value & 'h7F) > MAX_ROWS) ? MAX_ROWS : (value & 'h7F);
        end else begin
            nc = ((value & 'h1FF) > MAX_COLS) ? MAX_COLS : (value & 'h1FF);
        end
    endtask

    // Waits for the block to go idle: no result outstanding and no query in work.
    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // One input beat; called and returning at a falling edge.
    task automatic send(logic op, int r, int c, logic [15:0] s, int o);
        if (!no_gaps) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(0, 14)) @(negedge i_clk);
        end
        in_ch.opcode = op;
        in_ch.row = ROW_W'(r);
        in_ch.column = COL_W'(c);
        in_ch.sample = s;
        in_ch.other_row = ROW_W'(o);
        in_ch.valid = 1'b1;
        while (!in_ch.ready) @(negedge i_clk);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        if (op == OP_WRITE && r < nr && c < nc) begin
            shadow[r][c] = s;
            written[r][c] = 1'b1;
        end
    endtask

    function automatic bit row_complete(int r);
        for (int c = 0; c < nc; c++) begin
            if (!written[r][c]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Fill a whole row in one of several shapes relative to a base row.
    task automatic fill_row(int r, int shape, int base);
        logic signed [15:0] v;
        logic [15:0]        k;
        k = 16'($urandom);
        for (int c = 0; c < nc; c++) begin
            case (shape)
                0: v = 16'($urandom);
                1: v = k;
                2: v = shadow[base][c];
                3: v = (shadow[base][c] == -16'sd32768) ? 16'sd32767 : -shadow[base][c];
                4: v = c[0] ? 16'sh7FFF : 16'sh8000;
                default: v = 16'($signed($urandom_range(0, 6)) - 3);
            endcase
            send(OP_WRITE, r, c, v, $urandom_range(0, 63));
        end
    endtask

    task automatic random_query();
        int ra, rb, tries;
        tries = 0;
        do begin
            ra = $urandom_range(0, nr - 1);
            rb = $urandom_range(0, nr - 1);
            tries++;
        end while (!(row_complete(ra) && row_complete(rb)) && tries < 200);
        if (row_complete(ra) && row_complete(rb)) begin
            send(OP_QUERY, ra, $urandom_range(0, 255), 16'($urandom), rb);
        end
    endtask

    // One setting: fill some rows, query row 0 against each of them, then mix.
    task automatic run_phase(int rows, int cols, int n_random, bit pause_once);
        int k, pick, r;
        cfg_write(CFG_ROW_COUNT, rows);
        cfg_write(CFG_COL_COUNT, cols);
        k = (nr < 6) ? nr : 6;
        // With long rows fewer rows are filled, down to one, as far as the beat budget allows.
        while (k > 1 && k * nc > 24) k--;
        for (int i = 0; i < k; i++) begin
            fill_row(i, i, 0);
        end
        for (int i = 0; i < k; i++) begin
            send(OP_QUERY, 0, 0, 16'h0, i);
        end
        if (nr < MAX_ROWS) begin
            send(OP_QUERY, nr, 0, 16'h0, 0);
            send(OP_QUERY, 0, 0, 16'h0, 63);
        end
        for (int i = 0; i < n_random; i++) begin
            if (pause_once && i == n_random / 2) begin
                while (pending != 0) @(negedge i_clk);
            end
            if (i % 5 == 0) begin
                no_gaps = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                r = $urandom_range(0, k - 1);
                send(OP_WRITE, r, (nc > 0) ? $urandom_range(0, nc - 1) : 0,
                     16'($urandom), $urandom_range(0, 63));
            end else if (pick < 60) begin
                send(OP_WRITE, $urandom_range(0, 63), $urandom_range(0, 255),
                     16'($urandom), $urandom_range(0, 63));
            end else if (pick < 90 || nr == MAX_ROWS) begin
                random_query();
            end else begin
                send(OP_QUERY, $urandom_range(nr, 63), $urandom_range(0, 255),
                     16'($urandom), $urandom_range(0, 63));
            end
        end
        no_gaps = 1'b0;
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_ROW_COUNT;
        cfg_data = '0;
        no_gaps = 1'b0;
        nr = MAX_ROWS;
        nc = MAX_COLS;
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_WRITE;
        in_ch.row = '0;
        in_ch.column = '0;
        in_ch.sample = '0;
        in_ch.other_row = '0;
        foreach (written[r, c]) written[r][c] = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        run_phase(8, 4, 10, 1'b0);
        run_phase(64, 16, 10, 1'b1);
        run_phase(127, 1, 10, 1'b0);
        run_phase(5, 0, 10, 1'b0);
        run_phase(2, 511, 6, 1'b0);
        run_phase(20, 8, 10, 1'b0);
        run_phase(1, 3, 6, 1'b0);
        run_phase(63, 2, 10, 1'b0);

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
